>>> rtl/hsv_pkg.sv
// Shared constants, types and lane indexes for the HSV to RGB converter.
package hsv_pkg;

  localparam int unsigned HUE_W   = 9;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SEC_W   = 4;
  localparam int unsigned FRAC_W  = 6;

  localparam int unsigned PCT_FULL   = 100;
  localparam int unsigned DEG_SECTOR = 60;
  localparam int unsigned CHAN_MAX   = 255;
  localparam int unsigned NUM_SECTORS_SEEN = 8;

  // Scaled value 255*v (v <= 100) and weight 6000 - s*k (k <= 60).
  localparam int unsigned SCALE_W  = 15;
  localparam int unsigned WEIGHT_W = 13;
  localparam int unsigned WEIGHT_FULL = DEG_SECTOR * PCT_FULL;

  // Numerator 255*v*weight plus half of 600000 stays below 2**28.
  localparam int unsigned NUM_W       = 28;
  localparam int unsigned ROUND_BIAS  = (DEG_SECTOR * PCT_FULL * PCT_FULL) / 2;

  // Divide by 600000 = 64 * 9375: shift by 6, then multiply by a reciprocal
  // of 9375 that is exact for every 22-bit dividend.
  localparam int unsigned PRE_SHIFT   = 6;
  localparam int unsigned DIVD_W      = NUM_W - PRE_SHIFT;
  localparam int unsigned RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 24'd14660156;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam int unsigned PROD_W      = DIVD_W + RECIP_W;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned LANE_V = 0;
  localparam int unsigned LANE_P = 1;
  localparam int unsigned LANE_Q = 2;
  localparam int unsigned LANE_T = 3;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } hue_sector_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_div;
  } lane_ctl_t;

endpackage

>>> rtl/hsv_lane.sv
// One channel lane: scaled product, rounding bias and reciprocal divide by 600000.
module hsv_lane (
  input  logic                         clk,
  input  hsv_pkg::lane_ctl_t           ctl,
  input  logic [hsv_pkg::SCALE_W-1:0]  scale,
  input  logic [hsv_pkg::WEIGHT_W-1:0] weight,
  output logic [hsv_pkg::QUOT_W-1:0]   quot
);
  import hsv_pkg::*;

  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  num_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;

  assign num_nxt  = NUM_W'(scale) * NUM_W'(weight) + NUM_W'(ROUND_BIAS);
  assign prod_nxt = PROD_W'(num_r[NUM_W-1:PRE_SHIFT]) * PROD_W'(RECIP_MULT);

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      num_r <= num_nxt;
    end
    if (ctl.ld_div) begin
      prod_r <= prod_nxt;
    end
  end

  assign quot = prod_r[PROD_W-1:RECIP_SHIFT];

endmodule

>>> rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB converter: five register stages from input word to output word.
// Takes one pixel word per clock while in_tready is high; a word accepted into stage
// one passes in order through the five-stage pipeline (sector decode, weights,
// product, reciprocal divide by 600000, channel placement) and stage five drives
// out_tvalid. Each stage holds its word while the stage after it is full and cannot
// advance, so a stall on the output drops nothing
// and bubbles close up. Saturation and value above 100 are clamped to 100; a hue of
// 360 or above takes the sector-five placement. Channels round half up.
module hsv_to_rgb_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // hue_degrees[8:0], saturation_pct[15:9], value_pct[22:16], 0
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);
  import hsv_pkg::*;

  // stage valids and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic ld1, ld2, ld3, ld4, ld5;

  assign ld5 = !v5_r || out_tready;
  assign ld4 = !v4_r || ld5;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;
  assign in_tready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_tvalid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
    end
  end

  // stage 1: clamp, sector and remainder
  logic [HUE_W-1:0]  hue;
  logic [PCT_W-1:0]  sat_in, val_in;
  logic [SEC_W-1:0]  sec_num;
  logic [HUE_W-1:0]  frac_wide;
  hue_sector_t       sec_nxt;
  hue_sector_t       sec1_r, sec2_r, sec3_r, sec4_r;
  logic [PCT_W-1:0]  sat1_r, sat1_nxt, val1_r, val1_nxt;
  logic [FRAC_W-1:0] frac1_r;

  assign hue    = in_tdata[HUE_W-1:0];
  assign sat_in = in_tdata[HUE_W +: PCT_W];
  assign val_in = in_tdata[HUE_W+PCT_W +: PCT_W];

  always_comb begin
    sec_num = '0;
    for (int i = 1; i <= NUM_SECTORS_SEEN; i++) begin
      if (hue >= HUE_W'(i * DEG_SECTOR)) sec_num = SEC_W'(i);
    end
    frac_wide = hue - HUE_W'(HUE_W'(sec_num) * HUE_W'(DEG_SECTOR));
    sec_nxt   = (sec_num > SEC_W'(SEC_5)) ? SEC_5 : hue_sector_t'(sec_num[2:0]);
    sat1_nxt  = (sat_in > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : sat_in;
    val1_nxt  = (val_in > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : val_in;
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      sec1_r  <= sec_nxt;
      frac1_r <= frac_wide[FRAC_W-1:0];
      sat1_r  <= sat1_nxt;
      val1_r  <= val1_nxt;
    end
  end

  // stage 2: scaled value and one weight per lane
  logic [SCALE_W-1:0]  scale2_r;
  logic [WEIGHT_W-1:0] weight2_r [NUM_LANES];
  logic [WEIGHT_W-1:0] weight_nxt [NUM_LANES];
  logic [FRAC_W-1:0]   frac_inv;

  always_comb begin
    frac_inv = FRAC_W'(DEG_SECTOR) - frac1_r;
    weight_nxt[LANE_V] = WEIGHT_W'(WEIGHT_FULL);
    weight_nxt[LANE_P] = WEIGHT_W'(WEIGHT_FULL)
                       - WEIGHT_W'(WEIGHT_W'(sat1_r) * WEIGHT_W'(DEG_SECTOR));
    weight_nxt[LANE_Q] = WEIGHT_W'(WEIGHT_FULL)
                       - WEIGHT_W'(WEIGHT_W'(sat1_r) * WEIGHT_W'(frac1_r));
    weight_nxt[LANE_T] = WEIGHT_W'(WEIGHT_FULL)
                       - WEIGHT_W'(WEIGHT_W'(sat1_r) * WEIGHT_W'(frac_inv));
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      sec2_r    <= sec1_r;
      scale2_r  <= SCALE_W'(SCALE_W'(val1_r) * SCALE_W'(CHAN_MAX));
      weight2_r <= weight_nxt;
    end
  end

  // stages 3 and 4: lanes
  lane_ctl_t         lane_ctl;
  logic [QUOT_W-1:0] quot [NUM_LANES];

  assign lane_ctl.ld_mul = ld3;
  assign lane_ctl.ld_div = ld4;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    hsv_lane u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .scale  (scale2_r),
      .weight (weight2_r[g]),
      .quot   (quot[g])
    );
  end

  always_ff @(posedge clk) begin
    if (ld3) sec3_r <= sec2_r;
    if (ld4) sec4_r <= sec3_r;
  end

  // stage 5: clamp and place channels by sector
  logic [CHAN_W-1:0] ch [NUM_LANES];
  logic [CHAN_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [CHAN_W-1:0] red_r, green_r, blue_r;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      ch[i] = (quot[i] > QUOT_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : quot[i][CHAN_W-1:0];
    end
    unique case (sec4_r)
      SEC_0: begin
        red_nxt = ch[LANE_V]; green_nxt = ch[LANE_T]; blue_nxt = ch[LANE_P];
      end
      SEC_1: begin
        red_nxt = ch[LANE_Q]; green_nxt = ch[LANE_V]; blue_nxt = ch[LANE_P];
      end
      SEC_2: begin
        red_nxt = ch[LANE_P]; green_nxt = ch[LANE_V]; blue_nxt = ch[LANE_T];
      end
      SEC_3: begin
        red_nxt = ch[LANE_P]; green_nxt = ch[LANE_Q]; blue_nxt = ch[LANE_V];
      end
      SEC_4: begin
        red_nxt = ch[LANE_T]; green_nxt = ch[LANE_P]; blue_nxt = ch[LANE_V];
      end
      default: begin
        red_nxt = ch[LANE_V]; green_nxt = ch[LANE_P]; blue_nxt = ch[LANE_Q];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {blue_r, green_r, red_r};

  // an empty output stage frees every stage before it
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v5_r |-> in_tready)
    else $error("input stalled with empty output stage");

  // a stalled word in stage four stays there
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && v5_r && !out_tready) |=> (v4_r && v5_r))
    else $error("word lost under output stall");

  // a full pipeline under stall takes no new word
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && v5_r && !out_tready) |-> !in_tready)
    else $error("word accepted into a full pipeline");

endmodule

>>> tb/hsv_rgb_checker.sv
// Scoreboard for the HSV to RGB converter: predicts each pixel and checks the result words.
module hsv_rgb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          checked_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import hsv_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  rgb_t expected_rgb [$];

  function automatic longint unsigned round_half_up(longint unsigned num,
                                                    longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic logic [CHAN_W-1:0] to_chan(longint unsigned x);
    return (x > CHAN_MAX) ? CHAN_MAX[CHAN_W-1:0] : x[CHAN_W-1:0];
  endfunction

  function automatic rgb_t predict_rgb(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat_raw,
                                       logic [PCT_W-1:0] val_raw);
    longint unsigned sat, val, v255, sector, frac, cv, cp, cq, ct, r, g, b;
    hue_sector_t placement;
    rgb_t rgb;
    sat  = (sat_raw > PCT_FULL) ? PCT_FULL : sat_raw;
    val  = (val_raw > PCT_FULL) ? PCT_FULL : val_raw;
    v255 = CHAN_MAX * val;
    cv   = round_half_up(v255, PCT_FULL);
    if (sat == 0) begin
      r = cv;
      g = cv;
      b = cv;
    end else begin
      sector = hue / DEG_SECTOR;
      frac   = hue - sector * DEG_SECTOR;
      cp = round_half_up(v255 * (PCT_FULL - sat), PCT_FULL * PCT_FULL);
      cq = round_half_up(v255 * (WEIGHT_FULL - sat * frac), WEIGHT_FULL * PCT_FULL);
      ct = round_half_up(v255 * (WEIGHT_FULL - sat * (DEG_SECTOR - frac)),
                         WEIGHT_FULL * PCT_FULL);
      // hue of 300 and up, including 360 and beyond, takes the last placement
      placement = (sector >= 5) ? SEC_5 : hue_sector_t'(sector);
      case (placement)
        SEC_0: begin r = cv; g = ct; b = cp; end
        SEC_1: begin r = cq; g = cv; b = cp; end
        SEC_2: begin r = cp; g = cv; b = ct; end
        SEC_3: begin r = cp; g = cq; b = cv; end
        SEC_4: begin r = ct; g = cp; b = cv; end
        default: begin r = cv; g = cp; b = cq; end
      endcase
    end
    rgb.red   = to_chan(r);
    rgb.green = to_chan(g);
    rgb.blue  = to_chan(b);
    return rgb;
  endfunction

  task automatic note_mismatch(input string what);
    if (fail_count < MAX_PRINTED)
      $display("[%0t] mismatch on result word %0d: %s", $time, checked_count, what);
    fail_count++;
  endtask

  task automatic compare_chan(input string name, input logic [CHAN_W-1:0] want,
                              input logic [CHAN_W-1:0] got);
    if (got !== want)
      note_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.red   = out_tdata[CHAN_W-1:0];
        got.green = out_tdata[2*CHAN_W-1:CHAN_W];
        got.blue  = out_tdata[3*CHAN_W-1:2*CHAN_W];
        if (expected_rgb.size() == 0) begin
          note_mismatch($sformatf("word %h arrived with nothing outstanding", out_tdata));
        end else begin
          want = expected_rgb.pop_front();
          compare_chan("red", want.red, got.red);
          compare_chan("green", want.green, got.green);
          compare_chan("blue", want.blue, got.blue);
          checked_count++;
        end
      end
      if (in_tvalid && in_tready)
        expected_rgb.push_back(predict_rgb(in_tdata[HUE_W-1:0],
                                           in_tdata[HUE_W+PCT_W-1:HUE_W],
                                           in_tdata[HUE_W+2*PCT_W-1:HUE_W+PCT_W]));
      pending_count = expected_rgb.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the HSV to RGB converter bench: clock, reset, pixel stimulus, flow control, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hsv_pkg::*;

  localparam int N_DIRECTED       = 24;
  localparam int RANDOM_PER_PHASE = 432;
  localparam int N_PHASES         = 4;
  localparam int QUIET_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 20;

  // per phase: free-running, sender gaps, receiver stalls, both
  localparam int PHASE_GAP   [N_PHASES] = '{0, 77, 0, 31};
  localparam int PHASE_STALL [N_PHASES] = '{0, 0, 77, 31};

  localparam int DIR_HUE [N_DIRECTED] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299,
                                          300, 359, 360, 420, 511, 200, 0, 100, 30, 90,
                                          150, 270, 333, 45};
  localparam int DIR_SAT [N_DIRECTED] = '{100, 100, 100, 100, 100, 100, 100, 100, 100, 100,
                                          100, 100, 100, 75, 127, 0, 0, 0, 127, 101,
                                          1, 50, 99, 64};
  localparam int DIR_VAL [N_DIRECTED] = '{100, 100, 100, 100, 100, 100, 100, 100, 100, 100,
                                          100, 100, 100, 80, 127, 100, 0, 127, 50, 64,
                                          1, 101, 99, 37};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int fail_count;
  int pending_count;
  int checked_count;

  hsv_to_rgb_converter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  hsv_rgb_checker scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // End the run when neither channel has moved a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the word until the converter takes it; valid stays high into the next word unless a gap is drawn.
  task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                            input logic [PCT_W-1:0] val);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, sat, hue};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every outstanding result word has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    @(posedge clk);
  endtask

  initial begin
    int pick;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_pixel(HUE_W'(DIR_HUE[i]), PCT_W'(DIR_SAT[i]), PCT_W'(DIR_VAL[i]));
    drain_results();

    for (int phase = 0; phase < N_PHASES; phase++) begin
      gap_pct   = PHASE_GAP[phase];
      stall_pct <= PHASE_STALL[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        hue = ($urandom_range(0, 99) < 90) ? HUE_W'($urandom_range(0, 360))
                                           : HUE_W'($urandom_range(0, 511));
        pick = $urandom_range(0, 99);
        if (pick < 10)      sat = '0;
        else if (pick < 16) sat = PCT_W'($urandom_range(101, 127));
        else if (pick < 22) sat = PCT_W'(PCT_FULL);
        else                sat = PCT_W'($urandom_range(1, 100));
        pick = $urandom_range(0, 99);
        if (pick < 6)       val = '0;
        else if (pick < 12) val = PCT_W'($urandom_range(101, 127));
        else                val = PCT_W'($urandom_range(0, 100));
        send_pixel(hue, sat, val);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words: all six hue sectors, hue 360 and above, grey,",
             checked_count);
    $display("clamped saturation and value, under free flow, sender gaps and output stalls.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
